FILE: rtl/mocal_pkg.sv
// ----------------------------------------------------------------------------
// mocal_pkg
// Shared types and constants for the magnetometer offset calibration block.
// ----------------------------------------------------------------------------
package mocal_pkg;

  localparam int unsigned RawWidth    = 16;
  localparam int unsigned SumWidth    = 17;
  localparam int unsigned CountWidth  = 16;

  localparam logic [CountWidth-1:0] SamplesReset = 16'd10000;

  localparam logic signed [RawWidth-1:0] RawMax = 16'sh7FFF;
  localparam logic signed [RawWidth-1:0] RawMin = -16'sh8000;

  // Input command codes carried in tuser.
  localparam logic CmdSample = 1'b0;
  localparam logic CmdStart  = 1'b1;

  // Per-axis control for one item as it moves into the result register.
  typedef struct packed {
    logic advance;
    logic clear;
    logic track;
    logic load;
  } axis_ctrl_t;

endpackage

FILE: rtl/mocal_axis.sv
// ----------------------------------------------------------------------------
// mocal_axis
// One axis: min/max tracker, offset sum register and corrected-sample path.
// ----------------------------------------------------------------------------
module mocal_axis (
  input  logic                                        clk,
  input  logic                                        rst,
  input  mocal_pkg::axis_ctrl_t                       ctrl,
  input  logic signed [mocal_pkg::RawWidth-1:0]       raw,
  output logic signed [mocal_pkg::SumWidth-1:0]       offset_after,
  output logic signed [mocal_pkg::RawWidth-1:0]       corrected
);

  logic signed [mocal_pkg::RawWidth-1:0] minimum;
  logic signed [mocal_pkg::RawWidth-1:0] maximum;
  logic signed [mocal_pkg::SumWidth-1:0] offset_sum;
  logic signed [mocal_pkg::RawWidth-1:0] minimum_next;
  logic signed [mocal_pkg::RawWidth-1:0] maximum_next;
  logic signed [mocal_pkg::SumWidth-1:0] sum_new;
  logic signed [17:0]                    diff;
  logic signed [17:0]                    diff_adj;
  logic signed [17:0]                    half;

  always_comb begin
    minimum_next = (raw < minimum) ? raw : minimum;
    maximum_next = (raw > maximum) ? raw : maximum;
    sum_new = $signed({minimum_next[15], minimum_next}) +
              $signed({maximum_next[15], maximum_next});
    offset_after = ctrl.load ? sum_new : offset_sum;
  end

  // Halving with truncation toward zero: odd negative values round up.
  always_comb begin
    diff = $signed({raw[15], raw, 1'b0}) - $signed({offset_after[16], offset_after});
    diff_adj = diff + $signed({17'd0, diff[17]});
    half = diff_adj >>> 1;
    if (half > $signed(18'sd32767)) begin
      corrected = mocal_pkg::RawMax;
    end else if (half < -$signed(18'sd32768)) begin
      corrected = mocal_pkg::RawMin;
    end else begin
      corrected = half[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      minimum    <= mocal_pkg::RawMax;
      maximum    <= mocal_pkg::RawMin;
      offset_sum <= '0;
    end else if (ctrl.advance) begin
      if (ctrl.clear) begin
        minimum <= mocal_pkg::RawMax;
        maximum <= mocal_pkg::RawMin;
      end else if (ctrl.track) begin
        minimum <= minimum_next;
        maximum <= maximum_next;
      end
      if (ctrl.load) begin
        offset_sum <= sum_new;
      end
    end
  end

endmodule

FILE: rtl/magnetometer_offset_calibration_top.sv
// ----------------------------------------------------------------------------
// magnetometer_offset_calibration_top
// Hard-iron offset calibration for a three-axis magnetometer stream.
//
//   Channel  Direction  Handshake                Payload
//   s_*      in         s_tvalid / s_tready      raw X/Y/Z, start command
//   m_*      out        m_tvalid / m_tready      corrected X/Y/Z, offsets, flags
//   cfg_*    in         cfg_valid / cfg_ready    calibration sample count
//
// One item is accepted per cycle unless the output stalls; each item passes
// through an input register and then a result register before it is presented.
// Tracker and offset state is updated as an item moves into the result
// register. The input register refills in the same cycle the result register
// is taken, so a stalled output halts the input without a bubble.
// Reset is synchronous; cfg_ready is always high.
// ----------------------------------------------------------------------------
module magnetometer_offset_calibration_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [47:0]   s_tdata,   // raw_x, raw_y, raw_z
  input  logic [0:0]    s_tuser,   // command
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [103:0]  m_tdata,   // corrected_x/y/z, offset_twice_x/y/z, zero pad
  output logic [1:0]    m_tuser,   // calibrating, calibration_done
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [15:0]   cfg_data   // calibration_samples
);

  logic [mocal_pkg::CountWidth-1:0] calibration_samples;
  logic [mocal_pkg::CountWidth-1:0] samples_left;
  logic [mocal_pkg::CountWidth-1:0] samples_left_next;
  logic [mocal_pkg::CountWidth-1:0] count_dec;
  logic                             in_calibration;
  logic                             in_calibration_next;

  logic                             in_valid;
  logic                             in_command;
  logic [47:0]                      in_raw;
  logic                             advance;
  logic                             done;
  mocal_pkg::axis_ctrl_t            ctrl;

  logic signed [mocal_pkg::SumWidth-1:0] offset_after [3];
  logic signed [mocal_pkg::RawWidth-1:0] corrected    [3];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      calibration_samples <= mocal_pkg::SamplesReset;
    end else if (cfg_valid && cfg_ready) begin
      calibration_samples <= cfg_data;
    end
  end

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_command <= s_tuser[0];
      in_raw     <= s_tdata;
    end
  end

  always_comb begin
    count_dec           = samples_left - 16'd1;
    ctrl.advance        = advance;
    ctrl.clear          = (in_command == mocal_pkg::CmdStart);
    ctrl.track          = (in_command == mocal_pkg::CmdSample) && in_calibration;
    done                = ctrl.track && (count_dec == '0);
    ctrl.load           = done;
    samples_left_next   = samples_left;
    in_calibration_next = in_calibration;
    if (ctrl.clear) begin
      samples_left_next   = (calibration_samples == '0) ? 16'd1 : calibration_samples;
      in_calibration_next = 1'b1;
    end else if (ctrl.track) begin
      samples_left_next = count_dec;
      if (done) begin
        in_calibration_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      samples_left   <= '0;
      in_calibration <= 1'b0;
    end else if (advance) begin
      samples_left   <= samples_left_next;
      in_calibration <= in_calibration_next;
    end
  end

  for (genvar a = 0; a < 3; a++) begin : g_axis
    mocal_axis u_axis (
      .clk          (clk),
      .rst          (rst),
      .ctrl         (ctrl),
      .raw          ($signed(in_raw[16*a +: 16])),
      .offset_after (offset_after[a]),
      .corrected    (corrected[a])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {5'd0, offset_after[2], offset_after[1], offset_after[0],
                  corrected[2], corrected[1], corrected[0]};
      m_tuser <= {done, in_calibration_next};
    end
  end

`ifndef SYNTH
  a_run_count : assert property (@(posedge clk) disable iff (rst)
    in_calibration == (samples_left != '0))
    else $error("calibration flag and sample counter disagree");

  a_start_enters : assert property (@(posedge clk) disable iff (rst)
    advance && ctrl.clear |=> in_calibration)
    else $error("start item did not enter calibration");

  a_done_leaves : assert property (@(posedge clk) disable iff (rst)
    advance && done |=> !in_calibration && m_tvalid && m_tuser[1])
    else $error("completed run did not leave calibration");

  a_done_flags : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> !m_tuser[0])
    else $error("result flags both calibrating and done");
`endif

endmodule
